// ===== hdl/irdl_pkg.sv =====
// irdl_pkg: shared constants, types and calibration tables of the ir distance linearizer
// no dependencies; imported by every other file of the block
`default_nettype none

package irdl_pkg;

    // channel layout
    localparam int NUM_CH   = 3;
    localparam int CH_FRONT = 0;
    localparam int CH_LEFT  = 1;
    localparam int CH_RIGHT = 2;

    // sample accumulation
    localparam int ADC_BITS         = 12;
    localparam int SAMPLES_PER_READ = 4;
    localparam int CNT_W            = $clog2(SAMPLES_PER_READ);
    localparam int SUM_W            = ADC_BITS + CNT_W;
    localparam int SCALE_BITS       = 4;
    localparam int CODE_W           = ADC_BITS + SCALE_BITS;

    // interpolation
    localparam int TABLE_POINTS = 12;
    localparam int SEG_W        = $clog2(TABLE_POINTS - 1);
    localparam int FRAC_BITS    = 8;
    localparam int Q_W          = FRAC_BITS + 1;
    localparam int NUM_W        = CODE_W + FRAC_BITS;
    localparam int RECIP_SHIFT  = 37;
    localparam int RECIP_W      = 28;
    localparam int PROD_W       = NUM_W + RECIP_W;

    // result and register widths
    localparam int DIST_W     = 14;
    localparam int ERR_W      = 15;
    localparam int OFFS_W     = 12;
    localparam int LIM_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN      = 3'd4;

    // register reset values
    localparam logic [OFFS_W-1:0] RST_OFFSET      = 12'd0;
    localparam logic [LIM_W-1:0]  RST_FRONT_LIMIT = 13'd1280;
    localparam logic [LIM_W-1:0]  RST_SIDE_LIMIT  = 13'd2560;
    localparam logic [LIM_W-1:0]  RST_TARGET      = 13'd1024;
    localparam logic [LIM_W-1:0]  RST_MARGIN      = 13'd128;

    typedef logic [CODE_W-1:0]        t_code;
    typedef logic signed [DIST_W-1:0] t_dist;

    typedef struct packed {
        logic signed [OFFS_W-1:0] offset;
        logic [LIM_W-1:0]         front_limit;
        logic [LIM_W-1:0]         side_limit;
        logic [LIM_W-1:0]         target;
        logic [LIM_W-1:0]         margin;
    } t_cfg;

    // calibration points in 1/16 adc code, point i stands for i+1 cm
    localparam t_code CAL_CODE16 [TABLE_POINTS] = '{
        16'd2780,  16'd3772,  16'd4765,  16'd26009, 16'd36135, 16'd40503,
        16'd44474, 16'd47651, 16'd50629, 16'd52615, 16'd54004, 16'd54799
    };

    localparam t_code CAL_SPAN [TABLE_POINTS-1] = '{
        CAL_CODE16[1]  - CAL_CODE16[0],
        CAL_CODE16[2]  - CAL_CODE16[1],
        CAL_CODE16[3]  - CAL_CODE16[2],
        CAL_CODE16[4]  - CAL_CODE16[3],
        CAL_CODE16[5]  - CAL_CODE16[4],
        CAL_CODE16[6]  - CAL_CODE16[5],
        CAL_CODE16[7]  - CAL_CODE16[6],
        CAL_CODE16[8]  - CAL_CODE16[7],
        CAL_CODE16[9]  - CAL_CODE16[8],
        CAL_CODE16[10] - CAL_CODE16[9],
        CAL_CODE16[11] - CAL_CODE16[10]
    };

    // ceil(2^RECIP_SHIFT / span): exact floor quotient while num * span < 2^RECIP_SHIFT
    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;

    localparam logic [RECIP_W-1:0] CAL_RECIP [TABLE_POINTS-1] = '{
        RECIP_W'((RECIP_ONE + CAL_SPAN[0]  - 64'd1) / CAL_SPAN[0]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[1]  - 64'd1) / CAL_SPAN[1]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[2]  - 64'd1) / CAL_SPAN[2]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[3]  - 64'd1) / CAL_SPAN[3]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[4]  - 64'd1) / CAL_SPAN[4]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[5]  - 64'd1) / CAL_SPAN[5]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[6]  - 64'd1) / CAL_SPAN[6]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[7]  - 64'd1) / CAL_SPAN[7]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[8]  - 64'd1) / CAL_SPAN[8]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[9]  - 64'd1) / CAL_SPAN[9]),
        RECIP_W'((RECIP_ONE + CAL_SPAN[10] - 64'd1) / CAL_SPAN[10])
    };

endpackage

`default_nettype wire

// ===== hdl/irdl_in_if.sv =====
// irdl_in_if: input channel, valid/ready plus one adc sample per sensor
// depends on irdl_pkg
`default_nettype none

interface irdl_in_if
    import irdl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] front_sample;
    logic [ADC_BITS-1:0] left_sample;
    logic [ADC_BITS-1:0] right_sample;

    modport source (
        output valid, front_sample, left_sample, right_sample,
        input  ready
    );

    modport sink (
        input  valid, front_sample, left_sample, right_sample,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/irdl_out_if.sv =====
// irdl_out_if: result channel, valid/ready plus distances, wall flags and lateral error
// depends on irdl_pkg
`default_nettype none

interface irdl_out_if
    import irdl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [DIST_W-1:0] front_dist;
    logic signed [DIST_W-1:0] left_dist;
    logic signed [DIST_W-1:0] right_dist;
    logic                    front_wall;
    logic                    left_wall;
    logic                    right_wall;
    logic signed [ERR_W-1:0] lateral_error;
    logic                    needs_correction;

    modport source (
        output valid, front_dist, left_dist, right_dist, front_wall, left_wall,
               right_wall, lateral_error, needs_correction,
        input  ready
    );

    modport sink (
        input  valid, front_dist, left_dist, right_dist, front_wall, left_wall,
               right_wall, lateral_error, needs_correction,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/ir_distance_linearizer_unit.sv =====
// ir_distance_linearizer_unit: top level, three-channel ir distance estimator
// depends on irdl_pkg, irdl_in_if, irdl_out_if, irdl_accum, irdl_interp, irdl_lateral
// throughput: one input beat per cycle while a closing beat finds room downstream;
//   every fourth beat closes a read and yields one result, passing the average,
//   segment select, multiply, distance, wall/error and result registers in order
// reset: synchronous active low; clears sums, beat count, pipeline valids, restores registers
`default_nettype none

module ir_distance_linearizer_unit
    import irdl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    irdl_in_if.sink               i_in,
    irdl_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    t_cfg r_cfg;

    // averaged inputs, scaled to 1/16 code
    logic  avg_valid;
    logic  avg_ready;
    t_code avg_x [NUM_CH];

    // interpolated distances
    logic  dist_valid;
    logic  dist_ready;
    t_dist chan_dist [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset      <= $signed(RST_OFFSET);
            r_cfg.front_limit <= RST_FRONT_LIMIT;
            r_cfg.side_limit  <= RST_SIDE_LIMIT;
            r_cfg.target      <= RST_TARGET;
            r_cfg.margin      <= RST_MARGIN;
        end else if (i_cfg_we) begin
            // indexes beyond the list are dropped, data masked to register width
            unique case (i_cfg_index)
                CFG_OFFSET:      r_cfg.offset      <= $signed(i_cfg_data[OFFS_W-1:0]);
                CFG_FRONT_LIMIT: r_cfg.front_limit <= i_cfg_data[LIM_W-1:0];
                CFG_SIDE_LIMIT:  r_cfg.side_limit  <= i_cfg_data[LIM_W-1:0];
                CFG_TARGET:      r_cfg.target      <= i_cfg_data[LIM_W-1:0];
                CFG_MARGIN:      r_cfg.margin      <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // sums four beats per channel; non-closing beats are taken even when downstream stalls
    irdl_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (avg_valid),
        .i_ready (avg_ready),
        .o_x     (avg_x)
    );

    // piecewise-linear lookup: compares against all points at once, then a
    // reciprocal multiply gives the exact floored fraction within the segment
    irdl_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (avg_valid),
        .o_ready  (avg_ready),
        .i_x      (avg_x),
        .i_offset (r_cfg.offset),
        .o_valid  (dist_valid),
        .i_ready  (dist_ready),
        .o_dist   (chan_dist)
    );

    // wall flags and lateral error, ending in the result register that drives o_out
    irdl_lateral u_lateral (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_valid),
        .o_ready (dist_ready),
        .i_dist  (chan_dist),
        .i_cfg   (r_cfg),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== hdl/irdl_accum.sv =====
// irdl_accum: per-channel sample sums and averaging, emits scaled averages once per read
// depends on irdl_pkg and irdl_in_if
`default_nettype none

module irdl_accum
    import irdl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    irdl_in_if.sink i_in,
    output logic    o_valid,
    input  logic    i_ready,
    output t_code   o_x [NUM_CH]
);

    logic [SUM_W-1:0] r_sum [NUM_CH];
    logic [SUM_W-1:0] n_sum [NUM_CH];
    logic [SUM_W-1:0] avg   [NUM_CH];
    logic [CNT_W-1:0] r_count;
    logic             r_valid;
    t_code            r_x [NUM_CH];
    logic             last;
    logic             take;

    // only the closing beat of a read needs room downstream
    assign last       = (r_count == CNT_W'(SAMPLES_PER_READ - 1));
    assign i_in.ready = !last || !r_valid || i_ready;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        n_sum[CH_FRONT] = r_sum[CH_FRONT] + SUM_W'(i_in.front_sample);
        n_sum[CH_LEFT]  = r_sum[CH_LEFT]  + SUM_W'(i_in.left_sample);
        n_sum[CH_RIGHT] = r_sum[CH_RIGHT] + SUM_W'(i_in.right_sample);
        for (int c = 0; c < NUM_CH; c++) begin
            avg[c] = SUM_W'(n_sum[c] / SAMPLES_PER_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (take) begin
                if (last) begin
                    r_count <= '0;
                    for (int c = 0; c < NUM_CH; c++) begin
                        r_sum[c] <= '0;
                    end
                end else begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= n_sum;
                end
            end
            if (take && last) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && last) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_x[c] <= {avg[c][ADC_BITS-1:0], {SCALE_BITS{1'b0}}};
            end
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;

endmodule

`default_nettype wire

// ===== hdl/irdl_interp.sv =====
// irdl_interp: segment search, reciprocal multiply and distance assembly for three channels
// depends on irdl_pkg
`default_nettype none

module irdl_interp
    import irdl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_code                    i_x [NUM_CH],
    input  logic signed [OFFS_W-1:0] i_offset,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_dist                    o_dist [NUM_CH]
);

    typedef enum logic [1:0] {
        SEG_BELOW,
        SEG_INNER,
        SEG_ABOVE
    } t_seg_mode;

    // segment select stage
    logic               r_a_valid;
    t_seg_mode          r_a_mode  [NUM_CH];
    logic [SEG_W-1:0]   r_a_seg   [NUM_CH];
    logic [NUM_W-1:0]   r_a_num   [NUM_CH];
    logic [RECIP_W-1:0] r_a_recip [NUM_CH];
    t_seg_mode          n_mode    [NUM_CH];
    logic [SEG_W-1:0]   n_seg     [NUM_CH];
    logic [NUM_W-1:0]   n_num     [NUM_CH];
    logic [RECIP_W-1:0] n_recip   [NUM_CH];

    // multiply stage
    logic               r_b_valid;
    t_seg_mode          r_b_mode [NUM_CH];
    logic [SEG_W-1:0]   r_b_seg  [NUM_CH];
    logic [PROD_W-1:0]  r_b_prod [NUM_CH];

    // distance stage
    logic               r_c_valid;
    t_dist              r_c_dist [NUM_CH];
    t_dist              n_dist   [NUM_CH];
    logic [Q_W-1:0]     q        [NUM_CH];

    logic ready_a;
    logic ready_b;
    logic ready_c;

    assign ready_c = !r_c_valid || i_ready;
    assign ready_b = !r_b_valid || ready_c;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            // lowest segment whose upper point is not below x
            n_seg[c] = '0;
            for (int k = TABLE_POINTS - 1; k >= 1; k--) begin
                if (i_x[c] <= CAL_CODE16[k]) begin
                    n_seg[c] = SEG_W'(k - 1);
                end
            end
            if (i_x[c] <= CAL_CODE16[0]) begin
                n_mode[c] = SEG_BELOW;
            end else if (i_x[c] >= CAL_CODE16[TABLE_POINTS-1]) begin
                n_mode[c] = SEG_ABOVE;
            end else begin
                n_mode[c] = SEG_INNER;
            end
            n_num[c]   = {i_x[c] - CAL_CODE16[n_seg[c]], {FRAC_BITS{1'b0}}};
            n_recip[c] = CAL_RECIP[n_seg[c]];
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            q[c] = r_b_prod[c][RECIP_SHIFT +: Q_W];
            case (r_b_mode[c])
                SEG_BELOW: n_dist[c] = DIST_W'(1 << FRAC_BITS);
                SEG_ABOVE: n_dist[c] = DIST_W'(TABLE_POINTS << FRAC_BITS) + DIST_W'(i_offset);
                default:   n_dist[c] = DIST_W'({SEG_W'(r_b_seg[c] + 1'b1), {FRAC_BITS{1'b0}}})
                                     + DIST_W'(q[c]) + DIST_W'(i_offset);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (ready_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a_mode  <= n_mode;
            r_a_seg   <= n_seg;
            r_a_num   <= n_num;
            r_a_recip <= n_recip;
        end
        if (ready_b) begin
            r_b_mode <= r_a_mode;
            r_b_seg  <= r_a_seg;
            for (int c = 0; c < NUM_CH; c++) begin
                r_b_prod[c] <= PROD_W'(r_a_num[c]) * PROD_W'(r_a_recip[c]);
            end
        end
        if (ready_c) begin
            r_c_dist <= n_dist;
        end
    end

    assign o_valid = r_c_valid;
    assign o_dist  = r_c_dist;

endmodule

`default_nettype wire

// ===== hdl/irdl_lateral.sv =====
// irdl_lateral: wall flags, lateral error and correction flag, with the result register
// depends on irdl_pkg and irdl_out_if
`default_nettype none

module irdl_lateral
    import irdl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_dist       i_dist [NUM_CH],
    input  t_cfg        i_cfg,
    irdl_out_if.source  o_out
);

    logic                    r_d_valid;
    t_dist                   r_d_dist [NUM_CH];
    logic [NUM_CH-1:0]       r_d_wall;
    logic signed [ERR_W-1:0] r_d_err;
    logic [NUM_CH-1:0]       n_wall;
    logic signed [ERR_W-1:0] n_err;
    logic signed [ERR_W-1:0] dist_f;
    logic signed [ERR_W-1:0] dist_l;
    logic signed [ERR_W-1:0] dist_r;
    logic signed [ERR_W-1:0] front_lim;
    logic signed [ERR_W-1:0] side_lim;
    logic signed [ERR_W-1:0] target;

    logic                    r_o_valid;
    t_dist                   r_o_dist [NUM_CH];
    logic [NUM_CH-1:0]       r_o_wall;
    logic signed [ERR_W-1:0] r_o_err;
    logic                    r_o_corr;
    logic signed [ERR_W:0]   err_x;
    logic signed [ERR_W:0]   mag;
    logic signed [ERR_W:0]   margin;

    logic ready_o;
    logic ready_d;

    assign ready_o = !r_o_valid || o_out.ready;
    assign ready_d = !r_d_valid || ready_o;
    assign o_ready = ready_d;

    always_comb begin
        dist_f    = ERR_W'(i_dist[CH_FRONT]);
        dist_l    = ERR_W'(i_dist[CH_LEFT]);
        dist_r    = ERR_W'(i_dist[CH_RIGHT]);
        front_lim = $signed({{(ERR_W - LIM_W){1'b0}}, i_cfg.front_limit});
        side_lim  = $signed({{(ERR_W - LIM_W){1'b0}}, i_cfg.side_limit});
        target    = $signed({{(ERR_W - LIM_W){1'b0}}, i_cfg.target});

        n_wall[CH_FRONT] = dist_f < front_lim;
        n_wall[CH_LEFT]  = dist_l < side_lim;
        n_wall[CH_RIGHT] = dist_r < side_lim;

        if (n_wall[CH_LEFT] && n_wall[CH_RIGHT]) begin
            n_err = dist_l - dist_r;
        end else if (n_wall[CH_LEFT]) begin
            n_err = dist_l - target;
        end else if (n_wall[CH_RIGHT]) begin
            n_err = target - dist_r;
        end else begin
            n_err = '0;
        end
    end

    always_comb begin
        err_x  = (ERR_W + 1)'(r_d_err);
        mag    = (err_x < 0) ? -err_x : err_x;
        margin = $signed({{(ERR_W + 1 - LIM_W){1'b0}}, i_cfg.margin});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (ready_d) begin
                r_d_valid <= i_valid;
            end
            if (ready_o) begin
                r_o_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_d) begin
            r_d_dist <= i_dist;
            r_d_wall <= n_wall;
            r_d_err  <= n_err;
        end
        if (ready_o) begin
            r_o_dist <= r_d_dist;
            r_o_wall <= r_d_wall;
            r_o_err  <= r_d_err;
            r_o_corr <= mag > margin;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.front_dist       = r_o_dist[CH_FRONT];
    assign o_out.left_dist        = r_o_dist[CH_LEFT];
    assign o_out.right_dist       = r_o_dist[CH_RIGHT];
    assign o_out.front_wall       = r_o_wall[CH_FRONT];
    assign o_out.left_wall        = r_o_wall[CH_LEFT];
    assign o_out.right_wall       = r_o_wall[CH_RIGHT];
    assign o_out.lateral_error    = r_o_err;
    assign o_out.needs_correction = r_o_corr;

endmodule

`default_nettype wire

// ===== bench/ir_distance_linearizer_unit_tb.sv =====
// ir_distance_linearizer_unit_tb: self-checking bench for the ir distance linearizer
// random and directed sample beats against a scoreboard that predicts every read
// depends on irdl_pkg, irdl_in_if, irdl_out_if and ir_distance_linearizer_unit
`timescale 1ns / 100ps

module ir_distance_linearizer_unit_tb;
    import irdl_pkg::*;

    // bench constants
    localparam int BEATS_PER_READ   = 4;
    localparam int CURVE_POINTS     = 12;
    localparam int Q_ONE            = 256;
    localparam int ADC_MAX          = 4095;
    localparam int NUM_REGS         = CFG_MARGIN + 1;
    localparam int PIPE_SETTLE      = 10;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int NUM_PHASES       = 8;
    localparam int BEATS_PER_PHASE  = 247;

    // calibration curve in 1/16 adc code, point i is (i+1) cm
    localparam int CURVE_CODE16 [CURVE_POINTS] = '{
        2780, 3772, 4765, 26009, 36135, 40503,
        44474, 47651, 50629, 52615, 54004, 54799
    };

    // one result beat as seen on the output channel
    typedef struct packed {
        t_dist                   front_dist;
        t_dist                   left_dist;
        t_dist                   right_dist;
        logic                    front_wall;
        logic                    left_wall;
        logic                    right_wall;
        logic signed [ERR_W-1:0] lateral_error;
        logic                    needs_correction;
    } t_reading;

    // scoreboard: mirrors the registers and the running sums, queues predicted readings
    class t_scoreboard;
        int          offset;
        int          front_limit;
        int          side_limit;
        int          target;
        int          margin;
        int unsigned sums [3];
        int          beats_in_read;
        t_reading    expected_q [$];
        int          errors;
        int          checked;

        function new();
            offset        = 0;
            front_limit   = 1280;
            side_limit    = 2560;
            target        = 1024;
            margin        = 128;
            sums          = '{0, 0, 0};
            beats_in_read = 0;
            errors        = 0;
            checked       = 0;
        endfunction

        // register write as the block sees it: masked, unknown index dropped
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OFFSET:      offset      = int'($signed(data[OFFS_W-1:0]));
                CFG_FRONT_LIMIT: front_limit = int'(data[LIM_W-1:0]);
                CFG_SIDE_LIMIT:  side_limit  = int'(data[LIM_W-1:0]);
                CFG_TARGET:      target      = int'(data[LIM_W-1:0]);
                CFG_MARGIN:      margin      = int'(data[LIM_W-1:0]);
                default: ;
            endcase
        endfunction

        // average code to distance in cm q.8
        function int distance_of(int unsigned avg);
            int x;
            int lo;
            int hi;
            x = int'(avg) * 16;
            if (x <= CURVE_CODE16[0]) return Q_ONE;
            if (x >= CURVE_CODE16[CURVE_POINTS-1]) return CURVE_POINTS * Q_ONE + offset;
            for (int i = 0; i < CURVE_POINTS - 1; i++) begin
                lo = CURVE_CODE16[i];
                hi = CURVE_CODE16[i+1];
                if (x >= lo && x <= hi) begin
                    return (i + 1) * Q_ONE + ((x - lo) * Q_ONE) / (hi - lo) + offset;
                end
            end
            return CURVE_POINTS * Q_ONE + offset;
        endfunction

        function void note_sample(logic [ADC_BITS-1:0] f, logic [ADC_BITS-1:0] l,
                                  logic [ADC_BITS-1:0] r);
            int       dist_q8 [3];
            bit       wall [3];
            int       err;
            int       mag;
            t_reading want;
            sums[0] += f;
            sums[1] += l;
            sums[2] += r;
            beats_in_read++;
            if (beats_in_read < BEATS_PER_READ) return;
            for (int c = 0; c < 3; c++) begin
                dist_q8[c] = distance_of(sums[c] / BEATS_PER_READ);
                sums[c] = 0;
            end
            beats_in_read = 0;
            wall[0] = dist_q8[0] < front_limit;
            wall[1] = dist_q8[1] < side_limit;
            wall[2] = dist_q8[2] < side_limit;
            if (wall[1] && wall[2]) err = dist_q8[1] - dist_q8[2];
            else if (wall[1])      err = dist_q8[1] - target;
            else if (wall[2])      err = target - dist_q8[2];
            else                   err = 0;
            mag = (err < 0) ? -err : err;
            want.front_dist       = DIST_W'(dist_q8[0]);
            want.left_dist        = DIST_W'(dist_q8[1]);
            want.right_dist       = DIST_W'(dist_q8[2]);
            want.front_wall       = wall[0];
            want.left_wall        = wall[1];
            want.right_wall       = wall[2];
            want.lateral_error    = ERR_W'(err);
            want.needs_correction = mag > margin;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_reading(t_reading got);
            t_reading want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with no reading pending, expected none, actual %p",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("front_dist", want.front_dist, got.front_dist);
            compare_field("left_dist", want.left_dist, got.left_dist);
            compare_field("right_dist", want.right_dist, got.right_dist);
            compare_field("front_wall", want.front_wall, got.front_wall);
            compare_field("left_wall", want.left_wall, got.left_wall);
            compare_field("right_wall", want.right_wall, got.right_wall);
            compare_field("lateral_error", want.lateral_error, got.lateral_error);
            compare_field("needs_correction", want.needs_correction, got.needs_correction);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    irdl_in_if  in_if ();
    irdl_out_if out_if ();

    ir_distance_linearizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_scoreboard sb = new();

    // sink side controls, set by the stimulus process
    bit sink_quiet   = 1'b0;
    bit hold_request = 1'b0;

    // per-read sample levels, one per channel
    int level [3];
    int beats_sent = 0;
    int settings   = 1;

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result sampling at the rising edge, both handshake sides stable here
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_reading('{out_if.front_dist, out_if.left_dist, out_if.right_dist,
                               out_if.front_wall, out_if.left_wall, out_if.right_wall,
                               out_if.lateral_error, out_if.needs_correction});
        end
    end

    // result sink: random ready bursts, a long hold on request, always ready when quiet
    initial begin
        int burst;
        bit stalling;
        burst    = 0;
        stalling = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                // long hold, the block must fill and push back on its input
                out_if.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
                burst = 0;
            end else if (sink_quiet) begin
                out_if.ready <= 1'b1;
            end else begin
                if (burst == 0) begin
                    burst    = $urandom_range(1, 10);
                    stalling = ($urandom_range(0, 2) == 0);
                end
                burst--;
                out_if.ready <= !stalling;
            end
        end
    end

    // one sample beat, held until the block takes it
    task automatic send_sample(input logic [ADC_BITS-1:0] f, input logic [ADC_BITS-1:0] l,
                               input logic [ADC_BITS-1:0] r);
        @(negedge i_clk);
        in_if.valid        <= 1'b1;
        in_if.front_sample <= f;
        in_if.left_sample  <= l;
        in_if.right_sample <= r;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_sample(f, l, r);
        beats_sent++;
    endtask

    // input idle cycles, payload scrambled while valid is low
    task automatic idle_input(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_if.valid        <= 1'b0;
            in_if.front_sample <= ADC_BITS'($urandom);
            in_if.left_sample  <= ADC_BITS'($urandom);
            in_if.right_sample <= ADC_BITS'($urandom);
        end
    endtask

    // four identical beats, the average equals the sample
    task automatic send_read(input int f, input int l, input int r);
        repeat (BEATS_PER_READ) send_sample(ADC_BITS'(f), ADC_BITS'(l), ADC_BITS'(r));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stop sending, let every pending reading come out, then let the pipe settle
    task automatic drain();
        idle_input(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    function automatic int clip_code(int v);
        if (v < 0) return 0;
        if (v > ADC_MAX) return ADC_MAX;
        return v;
    endfunction

    // level for one channel of one read: uniform, near a breakpoint, near or far, rails
    function automatic int pick_level();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 25) return $urandom_range(0, ADC_MAX);
        if (mode < 50)
            return clip_code(CURVE_CODE16[$urandom_range(0, CURVE_POINTS-1)] / 16
                             + int'($urandom_range(0, 6)) - 3);
        if (mode < 70) return $urandom_range(0, 300);
        if (mode < 85) return $urandom_range(3300, ADC_MAX);
        return ($urandom_range(0, 1) == 1) ? ADC_MAX : 0;
    endfunction

    // beat around the read level, sometimes pure noise
    function automatic logic [ADC_BITS-1:0] jittered(int lvl);
        if ($urandom_range(0, 9) == 0) return ADC_BITS'($urandom);
        return ADC_BITS'(clip_code(lvl + int'($urandom_range(0, 8)) - 4));
    endfunction

    task automatic run_random(input int n, input bit gaps);
        for (int i = 0; i < n; i++) begin
            // new levels at each read boundary
            if (beats_sent % BEATS_PER_READ == 0) begin
                for (int c = 0; c < 3; c++) level[c] = pick_level();
            end
            if (gaps && $urandom_range(0, 99) < 12) idle_input($urandom_range(1, 10));
            send_sample(jittered(level[0]), jittered(level[1]), jittered(level[2]));
        end
    endtask

    // register settings per phase, written only with the pipe empty
    task automatic configure_phase(input int ph);
        case (ph)
            1: begin
                // low extremes
                write_reg(CFG_OFFSET, CFG_DATA_W'(-1024));
                write_reg(CFG_FRONT_LIMIT, 13'd0);
                write_reg(CFG_SIDE_LIMIT, 13'd0);
                write_reg(CFG_TARGET, 13'd0);
                write_reg(CFG_MARGIN, 13'd0);
            end
            2: begin
                // high extremes
                write_reg(CFG_OFFSET, CFG_DATA_W'(1024));
                write_reg(CFG_FRONT_LIMIT, 13'd4096);
                write_reg(CFG_SIDE_LIMIT, 13'd4096);
                write_reg(CFG_TARGET, 13'd4096);
                write_reg(CFG_MARGIN, 13'd4096);
            end
            3: begin
                // bit 12 of the offset write must be dropped, register widths at full scale
                write_reg(CFG_OFFSET, 13'h1800);
                write_reg(CFG_FRONT_LIMIT, 13'h1fff);
                write_reg(CFG_SIDE_LIMIT, 13'h1fff);
                write_reg(CFG_TARGET, 13'h1fff);
                write_reg(CFG_MARGIN, 13'd0);
            end
            default: begin
                write_reg(CFG_OFFSET, CFG_DATA_W'(int'($urandom_range(0, 2048)) - 1024));
                write_reg(CFG_FRONT_LIMIT, CFG_DATA_W'($urandom_range(0, 4096)));
                write_reg(CFG_SIDE_LIMIT, CFG_DATA_W'($urandom_range(0, 4096)));
                write_reg(CFG_TARGET, CFG_DATA_W'($urandom_range(0, 4096)));
                write_reg(CFG_MARGIN, CFG_DATA_W'($urandom_range(0, 1024)));
            end
        endcase
        // write to an unused index, must not disturb anything
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        settings++;
    endtask

    // main stimulus
    initial begin
        // every input known from time zero
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.front_sample = '0;
        in_if.left_sample  = '0;
        in_if.right_sample = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed reads under reset settings
        send_read(0, 0, 0);                 // all at or below the first point, both walls
        send_read(ADC_MAX, ADC_MAX, ADC_MAX); // all past the last point, no side wall
        send_read(173, 174, ADC_MAX);       // just below / just above first point, left only
        send_read(3424, 3425, 174);         // just below / just above last point, right wall only
        // floored average of unequal beats
        send_sample(12'd0, 12'd4095, 12'd1000);
        send_sample(12'd1, 12'd4095, 12'd2000);
        send_sample(12'd2, 12'd4095, 12'd3000);
        send_sample(12'd2, 12'd4094, 12'd1);
        send_read(1700, 2500, 2900);        // mid-segment interpolation
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) configure_phase(ph);
            // long output hold while the sender keeps offering beats
            if (ph == 2) hold_request = 1'b1;
            // no idling on either side in the closing phase
            if (ph == NUM_PHASES - 1) sink_quiet = 1'b1;
            run_random(BEATS_PER_PHASE, (ph != 5) && (ph != NUM_PHASES - 1));
            drain();
        end

        $display("covered %0d sample beats, %0d readings checked over %0d register settings,",
                 beats_sent, sb.checked, settings);
        $display("with rail and breakpoint samples, a long output hold and drained pauses");
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/irdl_pkg.sv
hdl/irdl_in_if.sv
hdl/irdl_out_if.sv
hdl/irdl_accum.sv
hdl/irdl_interp.sv
hdl/irdl_lateral.sv
hdl/ir_distance_linearizer_unit.sv
bench/ir_distance_linearizer_unit_tb.sv
